@@ hw/rtl/isrt_pkg.sv @@
// isrt_pkg: shared constants and types for the insertion sorter
// no dependencies; imported by isrt_cell and insertion_sorter_top
package isrt_pkg;

  localparam int unsigned MAX_ITEMS = 16;
  localparam int unsigned VAL_W     = 32;

  // what a cell shows its neighbors
  typedef struct packed {
    logic             vld;
    logic             gt;
    logic [VAL_W-1:0] val;
  } isrt_link_t;

  // broadcast control from the top level to every cell
  typedef struct packed {
    logic ins;
    logic pop;
  } isrt_ctrl_t;

endpackage

@@ hw/rtl/isrt_cell.sv @@
// isrt_cell: one slot of the sorted list, compares against the incoming value
// depends on isrt_pkg for the link and control structs
module isrt_cell
  import isrt_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  isrt_ctrl_t              ctrl_i,
  input  logic signed [VAL_W-1:0] ins_value_i,
  input  isrt_link_t              prev_i,
  input  isrt_link_t              next_i,
  output isrt_link_t              link_o
);

  logic             vld_q, vld_d;
  logic [VAL_W-1:0] val_q, val_d;
  logic             gt;

  assign gt = vld_q && ($signed(val_q) > ins_value_i);

  always_comb begin
    vld_d = vld_q;
    val_d = val_q;
    if (ctrl_i.pop) begin
      vld_d = next_i.vld;
      val_d = next_i.val;
    end else if (ctrl_i.ins) begin
      // equal values stay put, so the newcomer lands behind them
      if (!(vld_q && !gt) && prev_i.vld) begin
        vld_d = 1'b1;
        val_d = prev_i.gt ? prev_i.val : ins_value_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign link_o = '{vld: vld_q, gt: gt, val: val_q};

endmodule

@@ hw/rtl/insertion_sorter_top.sv @@
// insertion_sorter_top: stable insertion sorter built from a chain of isrt_cell
// depends on isrt_pkg and isrt_cell
//
//   channel | handshake               | payload
//   in      | in_valid_i / in_stall_o | value_i, final_item_i
//   out     | out_valid_o/ out_stall_i| sorted_value_o, end_of_run_o, overflow_o
//
// an element is inserted with all cells comparing and shifting in parallel
// after a final item the list drains from cell 0, one element per out transfer,
// so a block of n <= MAX_ITEMS elements costs n input and n output transfers
// input is stalled while the list drains
// reset clears the cell valid bits and the overflow mark; cell values need none
// a stalled output holds, since while draining cells only move on an out transfer
module insertion_sorter_top
  import isrt_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [VAL_W-1:0] value_i,
  input  logic                    final_item_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [VAL_W-1:0] sorted_value_o,
  output logic                    end_of_run_o,
  output logic                    overflow_o
);

  isrt_link_t link [MAX_ITEMS];
  isrt_ctrl_t ctrl;
  logic       drain_q, drain_d;
  logic       ovf_q, ovf_d;
  logic       in_xfer, out_xfer, full;

  assign full     = link[MAX_ITEMS-1].vld;
  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_xfer = out_valid_o && !out_stall_i;

  assign ctrl.ins = in_xfer && !full;
  assign ctrl.pop = out_xfer;

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    isrt_link_t prev_l, next_l;
    if (i == 0) begin : g_head
      assign prev_l = '{vld: 1'b1, gt: 1'b0, val: '0};
    end else begin : g_body
      assign prev_l = link[i-1];
    end
    if (i == MAX_ITEMS - 1) begin : g_tail
      assign next_l = '{vld: 1'b0, gt: 1'b0, val: '0};
    end else begin : g_mid
      assign next_l = link[i+1];
    end
    isrt_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .ins_value_i (value_i),
      .prev_i      (prev_l),
      .next_i      (next_l),
      .link_o      (link[i])
    );
  end

  always_comb begin
    drain_d = drain_q;
    ovf_d   = ovf_q;
    if (out_xfer && end_of_run_o) begin
      drain_d = 1'b0;
      ovf_d   = 1'b0;
    end else if (in_xfer) begin
      if (full) begin
        ovf_d = 1'b1;
      end
      if (final_item_i) begin
        drain_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drain_q <= 1'b0;
      ovf_q   <= 1'b0;
    end else begin
      drain_q <= drain_d;
      ovf_q   <= ovf_d;
    end
  end

  assign in_stall_o     = drain_q;
  assign out_valid_o    = drain_q && link[0].vld;
  assign sorted_value_o = link[0].val;
  assign end_of_run_o   = !link[1].vld;
  assign overflow_o     = ovf_q;

endmodule

@@ hw/rtl/isrt_checker.sv @@
// isrt_checker: port-level checks on insertion_sorter_top, bound to the top level
// depends on insertion_sorter_top ports only
module isrt_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic final_item_i,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic end_of_run_o
);

  // no input is taken while results go out
  a_stall_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while results pending");

  // a final item starts the list drain
  a_final_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && final_item_i) |=> out_valid_o)
    else $error("no result after final item");

  // other items cause no result
  a_quiet_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !final_item_i) |=> !out_valid_o)
    else $error("result without final item");

  // the last result ends the block
  a_run_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && end_of_run_o) |=> (!out_valid_o && !in_stall_o))
    else $error("output continues after end of run");

endmodule

bind insertion_sorter_top isrt_checker u_isrt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .final_item_i (final_item_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .end_of_run_o (end_of_run_o)
);
